### sv/hse_pkg.sv
`timescale 1ns / 1ps

package hse_pkg;

  // default capacity and element width
  localparam int unsigned DepthDefault      = 64;
  localparam int unsigned ValueWidthDefault = 32;

  // side flags that travel with each emitted item
  typedef struct packed {
    logic last;
    logic dropped;
  } emit_flags_t;

endpackage

### sv/hse_ram.sv
`timescale 1ns / 1ps

module hse_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrWidth = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrWidth-1:0] waddr_i,
  input  logic [Width-1:0]     wdata_i,
  input  logic                 re_i,
  input  logic [AddrWidth-1:0] raddr_i,
  output logic [Width-1:0]     rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, holds while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/hse_core.sv
`timescale 1ns / 1ps

module hse_core #(
  parameter int unsigned Depth      = hse_pkg::DepthDefault,
  parameter int unsigned ValueWidth = hse_pkg::ValueWidthDefault,
  localparam int unsigned AddrWidth = (Depth > 1) ? $clog2(Depth) : 1,
  localparam int unsigned CntWidth  = $clog2(Depth + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // input side
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [ValueWidth-1:0]      value_i,
  input  logic                       last_in_i,
  // emit side toward the output register
  input  logic                       slot_free_i,
  output logic                       emit_o,
  output logic [ValueWidth-1:0]      emit_value_o,
  output hse_pkg::emit_flags_t       emit_flags_o,
  // heap memory port
  output logic                       mem_we_o,
  output logic [AddrWidth-1:0]       mem_waddr_o,
  output logic [ValueWidth-1:0]      mem_wdata_o,
  output logic                       mem_re_o,
  output logic [AddrWidth-1:0]       mem_raddr_o,
  input  logic [ValueWidth-1:0]      mem_rdata_i
);

  import hse_pkg::*;

  typedef enum logic [11:0] {
    StLoad    = 12'b0000_0000_0001,
    StFetch   = 12'b0000_0000_0010,
    StFetchW  = 12'b0000_0000_0100,
    StSiftL   = 12'b0000_0000_1000,
    StSiftR   = 12'b0000_0001_0000,
    StSiftCmp = 12'b0000_0010_0000,
    StWrFinal = 12'b0000_0100_0000,
    StRdRoot  = 12'b0000_1000_0000,
    StRdEnd   = 12'b0001_0000_0000,
    StSwap    = 12'b0010_0000_0000,
    StEmitRd  = 12'b0100_0000_0000,
    StEmitW   = 12'b1000_0000_0000
  } state_e;

  localparam logic [CntWidth-1:0] DepthCnt = CntWidth'(Depth);

  state_e                  state_q, state_d;
  logic [CntWidth-1:0]     cnt_q, cnt_d;
  logic                    ovf_q, ovf_d;
  logic [AddrWidth-1:0]    pos_q, pos_d;
  logic [AddrWidth-1:0]    bound_q, bound_d;
  logic [AddrWidth-1:0]    idx_q, idx_d;
  logic                    build_q, build_d;
  logic                    has_r_q, has_r_d;
  logic [ValueWidth-1:0]   sv_q, sv_d;
  logic [ValueWidth-1:0]   lv_q, lv_d;

  logic [AddrWidth:0]      left_w;
  logic [AddrWidth:0]      right_w;
  logic [CntWidth-1:0]     n_after;
  logic                    take_right;
  logic [ValueWidth-1:0]   cval;
  logic                    emit_last;

  // child indices of the current sift position
  assign left_w  = {pos_q, 1'b1};
  assign right_w = left_w + (AddrWidth + 1)'(1);

  assign n_after    = (cnt_q < DepthCnt) ? cnt_q + CntWidth'(1) : cnt_q;
  assign take_right = has_r_q && ($signed(lv_q) < $signed(mem_rdata_i));
  assign cval       = take_right ? mem_rdata_i : lv_q;
  assign emit_last  = ({1'b0, idx_q} + (AddrWidth + 1)'(1)) == (AddrWidth + 1)'(cnt_q);

  assign in_ready_o          = (state_q == StLoad);
  assign emit_value_o        = mem_rdata_i;
  assign emit_flags_o.last   = emit_last;
  assign emit_flags_o.dropped = ovf_q;

  // sequencer: load, build heap, sort, emit
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ovf_d       = ovf_q;
    pos_d       = pos_q;
    bound_d     = bound_q;
    idx_d       = idx_q;
    build_d     = build_q;
    has_r_d     = has_r_q;
    sv_d        = sv_q;
    lv_d        = lv_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = pos_q;
    mem_wdata_o = sv_q;
    mem_re_o    = 1'b0;
    mem_raddr_o = idx_q;
    emit_o      = 1'b0;

    unique case (state_q)
      StLoad: begin
        if (in_valid_i) begin
          if (cnt_q < DepthCnt) begin
            mem_we_o    = 1'b1;
            mem_waddr_o = cnt_q[AddrWidth-1:0];
            mem_wdata_o = value_i;
            cnt_d       = cnt_q + CntWidth'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (last_in_i) begin
            if (n_after == CntWidth'(1)) begin
              idx_d   = '0;
              state_d = StEmitRd;
            end else begin
              bound_d = AddrWidth'(n_after - CntWidth'(1));
              idx_d   = AddrWidth'(n_after >> 1);
              build_d = 1'b1;
              state_d = StFetch;
            end
          end
        end
      end
      StFetch: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = idx_q - AddrWidth'(1);
        pos_d       = idx_q - AddrWidth'(1);
        state_d     = StFetchW;
      end
      StFetchW: begin
        sv_d    = mem_rdata_i;
        state_d = StSiftL;
      end
      StSiftL: begin
        if (left_w > {1'b0, bound_q}) begin
          state_d = StWrFinal;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = left_w[AddrWidth-1:0];
          state_d     = StSiftR;
        end
      end
      StSiftR: begin
        lv_d = mem_rdata_i;
        if (right_w <= {1'b0, bound_q}) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = right_w[AddrWidth-1:0];
          has_r_d     = 1'b1;
        end else begin
          has_r_d = 1'b0;
        end
        state_d = StSiftCmp;
      end
      StSiftCmp: begin
        // move the larger child up into the hole
        if ($signed(sv_q) < $signed(cval)) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = pos_q;
          mem_wdata_o = cval;
          pos_d       = take_right ? right_w[AddrWidth-1:0] : left_w[AddrWidth-1:0];
          state_d     = StSiftL;
        end else begin
          state_d = StWrFinal;
        end
      end
      StWrFinal: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = pos_q;
        mem_wdata_o = sv_q;
        if (idx_q > AddrWidth'(1)) begin
          idx_d   = idx_q - AddrWidth'(1);
          state_d = build_q ? StFetch : StRdRoot;
        end else if (build_q) begin
          build_d = 1'b0;
          idx_d   = bound_q;
          state_d = StRdRoot;
        end else begin
          idx_d   = '0;
          state_d = StEmitRd;
        end
      end
      StRdRoot: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = '0;
        state_d     = StRdEnd;
      end
      StRdEnd: begin
        lv_d        = mem_rdata_i;
        mem_re_o    = 1'b1;
        mem_raddr_o = idx_q;
        state_d     = StSwap;
      end
      StSwap: begin
        // old root goes to the end, old end value sifts from the root
        sv_d        = mem_rdata_i;
        mem_we_o    = 1'b1;
        mem_waddr_o = idx_q;
        mem_wdata_o = lv_q;
        bound_d     = idx_q - AddrWidth'(1);
        pos_d       = '0;
        state_d     = StSiftL;
      end
      StEmitRd: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = idx_q;
        state_d     = StEmitW;
      end
      StEmitW: begin
        if (slot_free_i) begin
          emit_o = 1'b1;
          if (emit_last) begin
            cnt_d   = '0;
            ovf_d   = 1'b0;
            state_d = StLoad;
          end else begin
            idx_d   = idx_q + AddrWidth'(1);
            state_d = StEmitRd;
          end
        end
      end
      default: begin
        state_d = StLoad;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      pos_q   <= '0;
      bound_q <= '0;
      idx_q   <= '0;
      build_q <= 1'b0;
      has_r_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
      pos_q   <= pos_d;
      bound_q <= bound_d;
      idx_q   <= idx_d;
      build_q <= build_d;
      has_r_q <= has_r_d;
    end
  end

  // value registers
  always_ff @(posedge clk_i) begin
    sv_q <= sv_d;
    lv_q <= lv_d;
  end

`ifndef SYNTHESIS
  a_emit_needs_slot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_o |-> slot_free_i)
    else $error("item emitted while output register busy");

  a_no_rw_same_addr : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we_o && mem_re_o) |-> (mem_waddr_o != mem_raddr_o))
    else $error("read and write of the same heap entry in one cycle");

  a_cnt_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DepthCnt)
    else $error("element count beyond capacity");

  a_last_ends_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_o && emit_flags_o.last) |=> (state_q == StLoad && cnt_q == '0))
    else $error("run not closed after last item");
`endif

endmodule

### sv/heap_sort_engine_unit.sv
`timescale 1ns / 1ps
// channel | valid       | ready       | payload
// input   | in_valid_i  | in_ready_o  | value_i, last_in_i
// output  | out_valid_o | out_ready_i | sorted_value_o, last_out_o, dropped_o
//
// loading takes one cycle per item; the item with last_in_i closes the run.
// sorting a run of n uses the single heap memory; each sift level steps through read left,
// read right, and compare and move; about n log2 n sift levels in all.
// emitting reads each result from memory, then loads it into the output register.
// in_ready_o is low from the closing item until the last result is in the output
// register; a stalled output holds the emitter. reset is asynchronous, active low.

module heap_sort_engine_unit #(
  parameter int unsigned DEPTH       = hse_pkg::DepthDefault,
  parameter int unsigned VALUE_WIDTH = hse_pkg::ValueWidthDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [VALUE_WIDTH-1:0] value_i,
  input  logic                   last_in_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [VALUE_WIDTH-1:0] sorted_value_o,
  output logic                   last_out_o,
  output logic                   dropped_o
);

  import hse_pkg::*;

  localparam int unsigned AddrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic                   mem_we;
  logic [AddrWidth-1:0]   mem_waddr;
  logic [VALUE_WIDTH-1:0] mem_wdata;
  logic                   mem_re;
  logic [AddrWidth-1:0]   mem_raddr;
  logic [VALUE_WIDTH-1:0] mem_rdata;

  logic                   emit;
  logic [VALUE_WIDTH-1:0] emit_value;
  emit_flags_t            emit_flags;
  logic                   slot_free;

  logic                   out_valid_q, out_valid_d;
  logic [VALUE_WIDTH-1:0] out_value_q;
  emit_flags_t            out_flags_q;

  // heap memory
  hse_ram #(
    .Width (VALUE_WIDTH),
    .Depth (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // load, heapify, sort and emit sequencer
  hse_core #(
    .Depth      (DEPTH),
    .ValueWidth (VALUE_WIDTH)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .value_i      (value_i),
    .last_in_i    (last_in_i),
    .slot_free_i  (slot_free),
    .emit_o       (emit),
    .emit_value_o (emit_value),
    .emit_flags_o (emit_flags),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_re_o     (mem_re),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata)
  );

  // output register
  assign slot_free   = !out_valid_q || out_ready_i;
  assign out_valid_d = emit || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_value_q <= emit_value;
      out_flags_q <= emit_flags;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sorted_value_o = out_value_q;
  assign last_out_o     = out_flags_q.last;
  assign dropped_o      = out_flags_q.dropped;

endmodule

### tb/heap_sort_engine_unit_tb.sv
`timescale 1ns / 1ps

module heap_sort_engine_unit_tb;

  localparam int unsigned Depth  = hse_pkg::DepthDefault;
  localparam int unsigned ValW   = hse_pkg::ValueWidthDefault;
  // longest stretch without any item moving: a full sort plus stalls, with margin
  localparam int unsigned HangLimit = 20000;
  localparam int unsigned MaxShown  = 25;

  typedef logic signed [ValW-1:0] elem_t;

  // one sorted element as it should leave the block
  typedef struct {
    elem_t                value;
    hse_pkg::emit_flags_t flags;
  } sorted_entry_t;

  // collects each run, sorts it and checks the emitted items in order
  class run_sort_checker;
    elem_t         run_vals[$];
    bit            run_overflow;
    sorted_entry_t sorted_due[$];
    int unsigned   mismatches;
    int unsigned   results_seen;
    int unsigned   runs_closed;
    int unsigned   runs_with_drop;

    function new();
      run_overflow   = 1'b0;
      mismatches     = 0;
      results_seen   = 0;
      runs_closed    = 0;
      runs_with_drop = 0;
    endfunction

    function int unsigned pending();
      return sorted_due.size();
    endfunction

    task flag_mismatch(input string msg);
      if (mismatches < MaxShown) $display("[%0t] mismatch: %s", $realtime, msg);
      mismatches++;
    endtask

    // accepted input item: store it, or on the closing item sort the run
    function void note_item(input elem_t v, input logic lst);
      sorted_entry_t e;
      elem_t         key;
      int            j;
      if (run_vals.size() < Depth) run_vals.push_back(v);
      else run_overflow = 1'b1;
      if (lst) begin
        // ascending insertion sort on signed values
        for (int i = 1; i < run_vals.size(); i++) begin
          key = run_vals[i];
          j   = i - 1;
          while (j >= 0 && run_vals[j] > key) begin
            run_vals[j+1] = run_vals[j];
            j--;
          end
          run_vals[j+1] = key;
        end
        foreach (run_vals[k]) begin
          e.value         = run_vals[k];
          e.flags.last    = (k == run_vals.size() - 1);
          e.flags.dropped = run_overflow;
          sorted_due.push_back(e);
        end
        runs_closed++;
        if (run_overflow) runs_with_drop++;
        run_vals.delete();
        run_overflow = 1'b0;
      end
    endfunction

    // accepted result item against the oldest expectation
    task check_emitted(input elem_t v, input logic lst, input logic drp);
      sorted_entry_t e;
      results_seen++;
      if (sorted_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected item value %0d last %b dropped %b", v, lst, drp));
      end else begin
        e = sorted_due.pop_front();
        if (v !== e.value)
          flag_mismatch($sformatf("sorted_value %0d, want %0d", v, e.value));
        if (lst !== e.flags.last)
          flag_mismatch($sformatf("last_out %b, want %b (value %0d)", lst, e.flags.last, e.value));
        if (drp !== e.flags.dropped)
          flag_mismatch($sformatf("dropped %b, want %b (value %0d)", drp, e.flags.dropped,
                                  e.value));
      end
    endtask
  endclass

  logic            clk_i       = 1'b0;
  logic            rst_ni      = 1'b0;
  logic            in_valid_i  = 1'b0;
  logic            in_ready_o;
  logic [ValW-1:0] value_i     = '0;
  logic            last_in_i   = 1'b0;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;
  logic [ValW-1:0] sorted_value_o;
  logic            last_out_o;
  logic            dropped_o;

  run_sort_checker ledger = new();
  bit              calm_tail   = 1'b0;
  bit              sender_calm = 1'b0;
  int unsigned     items_sent  = 0;
  int unsigned     stall_left  = 0;
  int unsigned     hang_count  = 0;

  heap_sort_engine_unit #(
    .DEPTH      (Depth),
    .VALUE_WIDTH(ValW)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .value_i       (value_i),
    .last_in_i     (last_in_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .sorted_value_o(sorted_value_o),
    .last_out_o    (last_out_o),
    .dropped_o     (dropped_o)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // receiver: ready with random stall bursts, none in the tail
  always @(negedge clk_i) begin
    if (calm_tail) begin
      out_ready_i <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left  = stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_ready_i <= 1'b0;
      stall_left  = $urandom_range(1, 11) - 1;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      ledger.check_emitted(sorted_value_o, last_out_o, dropped_o);
  end

  // hang detection: cycles in which no item moves on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) hang_count = 0;
    else hang_count = hang_count + 1;
    if (hang_count >= HangLimit) begin
      $display("no item moved for %0d cycles", HangLimit);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // one input item, with an optional idle burst ahead of it
  task automatic send_item(input elem_t v, input logic lst);
    int unsigned gap;
    @(negedge clk_i);
    if (!calm_tail && !sender_calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= v;
    last_in_i  <= lst;
    do @(posedge clk_i); while (!in_ready_o);
    ledger.note_item(v, lst);
    items_sent++;
  endtask

  // a whole run, closed by the last element
  task automatic send_run(input elem_t vals[$]);
    foreach (vals[k]) send_item(vals[k], k == vals.size() - 1);
  endtask

  // hold the sender until every sorted item has come out
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (ledger.pending() > 0) @(negedge clk_i);
  endtask

  // mix of full-range, small (many duplicates) and extreme values
  function automatic elem_t pick_value();
    case ($urandom_range(0, 5))
      0, 1, 2: return elem_t'($urandom);
      3:       return elem_t'($urandom_range(0, 15)) - 8;
      4: begin
        case ($urandom_range(0, 3))
          0:       return {1'b0, {(ValW-1){1'b1}}};
          1:       return {1'b1, {(ValW-1){1'b0}}};
          2:       return '0;
          default: return '1;
        endcase
      end
      default: return {$urandom_range(0, 1) == 1, {(ValW-1){1'b0}}} + $urandom_range(0, 3);
    endcase
  endfunction

  task automatic send_random_run(input int unsigned len);
    elem_t vals[$];
    sender_calm = ($urandom_range(0, 3) == 0);
    for (int unsigned k = 0; k < len; k++) vals.push_back(pick_value());
    send_run(vals);
  endtask

  initial begin
    elem_t       vals[$];
    elem_t       vmax;
    elem_t       vmin;
    int unsigned rand_items;
    vmax = {1'b0, {(ValW-1){1'b1}}};
    vmin = {1'b1, {(ValW-1){1'b0}}};

    // reset
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // single-element runs at both extremes pass through unchanged
    vals = '{vmax};
    send_run(vals);
    vals = '{vmin};
    send_run(vals);
    // small mixed-sign run and a two-element run of the extremes
    vals = '{elem_t'(0), elem_t'(-1), elem_t'(1)};
    send_run(vals);
    vals = '{vmax, vmin};
    send_run(vals);
    // equal values, duplicated minimum
    vals = '{elem_t'(5), elem_t'(5), elem_t'(-5), elem_t'(5), vmin, vmin};
    send_run(vals);
    // already in descending order
    vals = '{vmax, elem_t'(1000), elem_t'(7), elem_t'(0), elem_t'(-1), elem_t'(-7),
             elem_t'(-1000), vmin};
    send_run(vals);

    // random short runs
    rand_items = 0;
    while (rand_items < 26) begin
      vals.delete();
      send_random_run($urandom_range(1, 10));
      rand_items = items_sent;
    end

    // store exactly full, the last stored element closes the run
    wait_drained();
    send_random_run(Depth);
    // store overflows, the closing item itself is dropped
    send_random_run(Depth + $urandom_range(1, 4));
    send_random_run($urandom_range(1, 4));

    // tail with no idling on either side
    calm_tail = 1'b1;
    repeat (2) send_random_run($urandom_range(2, 8));

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (ledger.pending() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("covered %0d runs (%0d with dropped items) from %0d input items",
             ledger.runs_closed, ledger.runs_with_drop, items_sent);
    $display("checked %0d sorted items, %0d mismatches", ledger.results_seen,
             ledger.mismatches);
    if (ledger.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
sv/hse_pkg.sv
sv/hse_ram.sv
sv/hse_core.sv
sv/heap_sort_engine_unit.sv
tb/heap_sort_engine_unit_tb.sv
